@@ design/sliding_window_median_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window median assertion macros
// Shorthand for clocked assertions, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window median package
// Register map, configuration widths and the controller command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

	localparam int CFG_WIDTH   = 7;
	localparam int PDATA_WIDTH = 32;
	localparam int PADDR_WIDTH = 3;

	localparam logic [PADDR_WIDTH-3:0] REG_WINDOW_SIZE = 1'b0;

	localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

	typedef struct packed {
		logic load_sample;
		logic remove;
		logic insert;
		logic load_median;
		logic ram_we;
	} swm_cmd_t;

endpackage

@@ design/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// Sliding window median
// Running lower-median filter over the most recent window_size signed samples.
// No result is given until the window has filled; from then on every sample
// gives one median, the element of rank (window_size-1)/2 in ascending order.
// A window size of zero acts as one, a size above WINDOW_MAX acts as
// WINDOW_MAX, and writing the size register flushes the window. While the
// window fills, an item takes one insert pass; once it is full, the oldest
// sample comes out of the arrival ring RAM through its registered read, then
// the sorted cell row makes one pass to drop it and one pass to place the new
// sample. The median register loads in the first cycle in which the next item
// can be accepted, later only while the previous median is still stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic                                median_valid,
	input  logic                                median_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      median,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swm_pkg::PADDR_WIDTH-1:0]     paddr,
	input  logic [swm_pkg::PDATA_WIDTH-1:0]     pwdata,
	output logic [swm_pkg::PDATA_WIDTH-1:0]     prdata,
	output logic                                pready
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	swm_pkg::swm_cmd_t             cmd;
	logic [swm_pkg::CFG_WIDTH-1:0] size;
	logic [IW-1:0]                 ins_count;
	logic [IW-1:0]                 rm_last;
	logic [IW-1:0]                 med_idx;
	logic [IW-1:0]                 ram_waddr;
	logic [IW-1:0]                 ram_raddr;
	logic                          reg_hit;
	logic                          cfg_we;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[swm_pkg::PADDR_WIDTH-1:2] == swm_pkg::REG_WINDOW_SIZE);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ?
		{{(swm_pkg::PDATA_WIDTH - swm_pkg::CFG_WIDTH){1'b0}}, size} : '0;

	swm_ctrl #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_stall  (sample_stall),
		.out_valid (median_valid),
		.out_stall (median_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[swm_pkg::CFG_WIDTH-1:0]),
		.size      (size),
		.cmd       (cmd),
		.ins_count (ins_count),
		.rm_last   (rm_last),
		.med_idx   (med_idx),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	swm_dp #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk       (clk),
		.sample    (sample),
		.cmd       (cmd),
		.ins_count (ins_count),
		.rm_last   (rm_last),
		.med_idx   (med_idx),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.median    (median)
	);

endmodule

@@ design/swm_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/swm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sliding window median controller
// Holds the window size, fill and ring pointers, and sequences each item
// through the remove and insert passes of the sorted cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ctrl #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_valid,
	output logic                                           in_stall,
	output logic                                           out_valid,
	input  logic                                           out_stall,
	input  logic                                           cfg_we,
	input  logic [swm_pkg::CFG_WIDTH-1:0]                  cfg_wdata,
	output logic [swm_pkg::CFG_WIDTH-1:0]                  size,
	output swm_pkg::swm_cmd_t                              cmd,
	output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ins_count,
	output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rm_last,
	output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] med_idx,
	output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ram_waddr,
	output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ram_raddr
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int EW = $clog2(WINDOW_MAX + 1);
	localparam int XW = (EW > swm_pkg::CFG_WIDTH) ? EW : swm_pkg::CFG_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT
	} state_t;

	state_t                        state_q;
	logic [swm_pkg::CFG_WIDTH-1:0] size_q;
	logic [IW-1:0]                 fill_q;
	logic [IW-1:0]                 ptr_q;
	logic                          full_q;
	logic                          pend_q;
	logic                          out_valid_q;

	logic [XW-1:0] size_x;
	logic [IW-1:0] wm1;
	logic          out_free;
	logic          load_med;
	logic          accept;

	always_comb begin
		size_x = XW'(size_q);
		if (size_q == '0) begin
			wm1 = '0;
		end else if (size_x > XW'(WINDOW_MAX)) begin
			wm1 = IW'(WINDOW_MAX - 1);
		end else begin
			wm1 = IW'(size_x - XW'(1));
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load_med = (state_q == ST_IDLE) && pend_q && out_free;
	assign in_stall = (state_q != ST_IDLE) || (pend_q && !out_free);
	assign accept   = in_valid && !in_stall;

	assign cmd.load_sample = accept;
	assign cmd.remove      = (state_q == ST_REMOVE);
	assign cmd.insert      = (state_q == ST_INSERT);
	assign cmd.load_median = load_med;
	assign cmd.ram_we      = (state_q == ST_REMOVE) || ((state_q == ST_INSERT) && !full_q);

	assign ins_count = full_q ? wm1 : fill_q;
	assign rm_last   = wm1;
	assign med_idx   = wm1 >> 1;
	assign ram_waddr = full_q ? ptr_q : fill_q;
	assign ram_raddr = ptr_q;
	assign out_valid = out_valid_q;
	assign size      = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= swm_pkg::WINDOW_SIZE_RESET;
			fill_q      <= '0;
			ptr_q       <= '0;
			full_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_med) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= full_q ? ST_REMOVE : ST_INSERT;
					end
				end
				ST_REMOVE: begin
					ptr_q   <= (ptr_q == wm1) ? '0 : ptr_q + IW'(1);
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					if (full_q) begin
						pend_q <= 1'b1;
					end else if (fill_q == wm1) begin
						full_q <= 1'b1;
						ptr_q  <= '0;
						pend_q <= 1'b1;
					end else begin
						fill_q <= fill_q + IW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A new window size flushes the window.
			if (cfg_we) begin
				size_q <= cfg_wdata;
				fill_q <= '0;
				ptr_q  <= '0;
				full_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/swm_dp.sv @@
// ----------------------------------------------------------------------------
// Sliding window median datapath
// Arrival ring RAM, a row of sorted compare cells with remove and insert
// passes, and the median output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_dp #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                           clk,
	input  logic signed [SAMPLE_WIDTH-1:0]                 sample,
	input  swm_pkg::swm_cmd_t                              cmd,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ins_count,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] rm_last,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] med_idx,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ram_waddr,
	input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] ram_raddr,
	output logic signed [SAMPLE_WIDTH-1:0]                 median
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;
	logic signed [SAMPLE_WIDTH-1:0] sorted_q [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] rm_nxt   [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] ins_nxt  [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] oldest;
	logic        [SAMPLE_WIDTH-1:0] ram_rdata;
	logic        [WINDOW_MAX-1:0]   lt;
	logic        [WINDOW_MAX-1:0]   le;

	swm_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (ram_waddr),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign oldest = $signed(ram_rdata);

	// Cells below the oldest value keep their entry, the rest shift down by one.
	// On insert, cells at or below the new sample keep their entry, the first cell
	// above takes the sample and the rest shift up by one.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		assign lt[i] = (IW'(i) <= rm_last) && (sorted_q[i] < oldest);
		assign le[i] = (IW'(i) < ins_count) && (sorted_q[i] <= sample_q);

		if (i == WINDOW_MAX - 1) begin : g_top
			assign rm_nxt[i] = sorted_q[i];
		end else begin : g_mid
			assign rm_nxt[i] = lt[i] ? sorted_q[i] : sorted_q[i+1];
		end

		if (i == 0) begin : g_bottom
			assign ins_nxt[i] = le[i] ? sorted_q[i] : sample_q;
		end else begin : g_upper
			assign ins_nxt[i] = le[i] ? sorted_q[i] : (le[i-1] ? sample_q : sorted_q[i-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample;
		end
		if (cmd.remove) begin
			sorted_q <= rm_nxt;
		end else if (cmd.insert) begin
			sorted_q <= ins_nxt;
		end
		if (cmd.load_median) begin
			median_q <= sorted_q[med_idx];
		end
	end

	assign median = median_q;

endmodule

@@ design/swm_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding window median checker
// Port-level checks on the item handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sliding_window_median_defines.svh"

module swm_checker #(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    sample_valid,
	input logic                    sample_stall,
	input logic                    median_valid,
	input logic                    median_stall,
	input logic [SAMPLE_WIDTH-1:0] median
);

	// The input is stalled in the cycle after an item is accepted.
	`SWM_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "item accepted on consecutive cycles")

	`SWM_ASSERT_NEXT(a_median_held, median_valid && median_stall, median_valid && $stable(median), "stalled median changed or dropped")

	// A fresh median follows an insert pass, during which input is stalled.
	`SWM_ASSERT_NOW(a_median_after_update, $rose(median_valid), $past(sample_stall, 2), "median appeared without an update pass")

endmodule

bind sliding_window_median swm_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.median_valid (median_valid),
	.median_stall (median_stall),
	.median       (median)
);

@@ tb/swm_median_checker.sv @@
// ----------------------------------------------------------------------------
// Sliding window median checker
// Follows window size writes on the register port and every accepted sample,
// keeps its own arrival ring and sorted copy of the window, and queues the
// lower median that each sample gives once the window is full. Every
// accepted median is compared with the oldest one queued. Mismatches and
// the number of medians still due are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_median_checker #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	input  logic                                sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  logic                                median_valid,
	input  logic                                median_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]      median,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swm_pkg::PADDR_WIDTH-1:0]     paddr,
	input  logic [swm_pkg::PDATA_WIDTH-1:0]     pwdata,
	input  logic                                pready,
	output int                                  mismatch_count,
	output int                                  medians_pending
);

	localparam logic [swm_pkg::PADDR_WIDTH-1:0] WINDOW_SIZE_ADDR =
		{swm_pkg::REG_WINDOW_SIZE, 2'b00};

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	logic [swm_pkg::CFG_WIDTH-1:0] window_cfg;
	sample_t arrival_ring [WINDOW_MAX];
	sample_t sorted_window [$];
	sample_t medians_due [$];
	int fill_count;
	int oldest_slot;

	initial mismatch_count = 0;

	function automatic int effective_window();
		if (window_cfg == 0) return 1;
		if (window_cfg > WINDOW_MAX) return WINDOW_MAX;
		return int'(window_cfg);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_median(input sample_t got);
		sample_t due;
		if (medians_due.size() == 0) begin
			report_mismatch($sformatf("median %0d arrived with none due", got));
		end else begin
			due = medians_due.pop_front();
			if (got !== due)
				report_mismatch($sformatf("median %0d, expected %0d", got, due));
		end
	endtask

	task automatic queue_median(input sample_t value);
		medians_due = {medians_due, value};
	endtask

	task automatic take_sample(input sample_t value);
		int span;
		int pos;
		sample_t oldest;
		span = effective_window();
		if (fill_count < span) begin
			arrival_ring[fill_count] = value;
			fill_count++;
			oldest_slot = 0;
		end else begin
			// Exactly one copy of the oldest value leaves the sorted window.
			oldest = arrival_ring[oldest_slot];
			pos = 0;
			while (pos < sorted_window.size() && sorted_window[pos] != oldest) pos++;
			if (pos < sorted_window.size()) sorted_window.delete(pos);
			arrival_ring[oldest_slot] = value;
			oldest_slot = (oldest_slot + 1 < span) ? oldest_slot + 1 : 0;
		end
		pos = 0;
		while (pos < sorted_window.size() && sorted_window[pos] <= value) pos++;
		sorted_window.insert(pos, value);
		if (fill_count == span) queue_median(sorted_window[(span - 1) / 2]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_cfg = swm_pkg::WINDOW_SIZE_RESET;
			fill_count = 0;
			oldest_slot = 0;
			sorted_window.delete();
			medians_due.delete();
			medians_pending <= 0;
		end else begin
			if (median_valid && !median_stall) check_median(median);
			if (psel && penable && pwrite && pready && paddr == WINDOW_SIZE_ADDR) begin
				window_cfg = pwdata[swm_pkg::CFG_WIDTH-1:0];
				fill_count = 0;
				oldest_slot = 0;
				sorted_window.delete();
			end
			if (sample_valid && !sample_stall) take_sample(sample);
			medians_pending <= medians_due.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Drives directed edge values and then random sample streams through a series
// of window sizes, the saturating and zero sizes among them, with random gaps
// on the sample side and random stalls on the median side. A checker beside
// the block predicts and compares every median; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int WINDOW_MAX    = 64;
	localparam int SAMPLE_WIDTH  = 32;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int QUIET_TAIL    = 200;

	localparam logic [swm_pkg::PADDR_WIDTH-1:0] WINDOW_SIZE_ADDR =
		{swm_pkg::REG_WINDOW_SIZE, 2'b00};

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
	localparam sample_t SAMPLE_MAX = ~SAMPLE_MIN;

	logic                               clk;
	logic                               arst_n;
	logic                               sample_valid;
	logic                               sample_stall;
	sample_t                            sample;
	logic                               median_valid;
	logic                               median_stall;
	sample_t                            median;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [swm_pkg::PADDR_WIDTH-1:0]    paddr;
	logic [swm_pkg::PDATA_WIDTH-1:0]    pwdata;
	logic [swm_pkg::PDATA_WIDTH-1:0]    prdata;
	logic                               pready;
	int                                 mismatch_count;
	int                                 medians_pending;
	bit                                 idling = 1'b1;

	sliding_window_median #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.median_valid(median_valid),
		.median_stall(median_stall),
		.median(median),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	swm_median_checker #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) median_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.median_valid(median_valid),
		.median_stall(median_stall),
		.median(median),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatch_count(mismatch_count),
		.medians_pending(medians_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		median_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 4) == 0) begin
				median_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				median_stall <= 1'b0;
			end
		end
	end

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) == 1) ? SAMPLE_MIN : SAMPLE_MAX;
			1, 2, 3: return sample_t'($urandom_range(0, 16) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(input sample_t value);
		if (idling && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	task automatic settle_window();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (medians_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [swm_pkg::CFG_WIDTH-1:0] cfg_value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_SIZE_ADDR;
		pwdata <= {{(swm_pkg::PDATA_WIDTH - swm_pkg::CFG_WIDTH){1'b0}}, cfg_value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int sent;
		int phase;
		int count;
		int span;
		logic [swm_pkg::CFG_WIDTH-1:0] cfg_pick;

		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(0);
		send_sample(-1);
		send_sample(1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(5);
		send_sample(5);
		send_sample(5);
		send_sample(32'sh5555_5555);
		send_sample(32'shAAAA_AAAA);
		settle_window();
		write_window(1);
		send_sample(7);
		send_sample(-7);
		settle_window();
		write_window(0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		settle_window();
		write_window(2);
		send_sample(3);
		send_sample(3);
		send_sample(-3);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: cfg_pick = 127;
				1: cfg_pick = 64;
				2: cfg_pick = 1;
				3: cfg_pick = 0;
				4: cfg_pick = 65;
				default: begin
					if ($urandom_range(0, 3) == 0)
						cfg_pick = 7'($urandom_range(0, 127));
					else
						cfg_pick = 7'($urandom_range(1, 12));
				end
			endcase
			span = (cfg_pick == 0) ? 1 : (cfg_pick > WINDOW_MAX) ? WINDOW_MAX : cfg_pick;
			if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, span);
			else
				count = span + $urandom_range(0, 60);
			settle_window();
			idling = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			write_window(cfg_pick);
			for (int i = 0; i < count; i++) begin
				if (phase % 5 == 1 && i == count / 2) settle_window();
				send_sample(random_sample());
			end
			sent += count;
			phase++;
		end

		idling = 1'b0;
		settle_window();
		if (mismatch_count == 0 && medians_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
